[sv/tpa_pkg.sv]
// Shared types and constants for the triangle primitive assembly block.
// No dependencies; imported by every module of the block.
package tpa_pkg;

  localparam int unsigned FIELD_W   = 32;  // index width on the ports
  localparam int unsigned MAX_BEATS = 3;   // results one index can cause

  typedef enum logic [1:0] {
    MODE_LIST  = 2'd0,
    MODE_STRIP = 2'd1,
    MODE_FAN   = 2'd2,
    MODE_BAD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_BAD_MODE  = 2'd2
  } status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] vertex_index_in;
    logic               final_index;
  } tpa_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] vertex_index_out;
    logic               triangle_done;
    logic               list_done;
    logic [1:0]         status;
  } tpa_out_t;

  // One classified index: how many beats it emits and the beats themselves.
  typedef struct packed {
    logic [1:0]                   count;
    tpa_out_t [MAX_BEATS-1:0]     beat;
  } tpa_job_t;

endpackage

[sv/tpa_front.sv]
// Front end: accepts indices, tracks primitive state, builds beat jobs.
// Depends on tpa_pkg.
module tpa_front import tpa_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  tpa_in_t  in_data,
  output logic     in_ready,
  input  mode_t    mode,
  input  logic     q_full,
  output logic     push,
  output tpa_job_t job
);

  logic [INDEX_WIDTH-1:0] first_r, first_nxt;
  logic [INDEX_WIDTH-1:0] older_r, older_nxt;
  logic [INDEX_WIDTH-1:0] newer_r, newer_nxt;
  logic [1:0]             seen_r, seen_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic                   odd_r, odd_nxt;

  logic                   accept;
  logic [INDEX_WIDTH-1:0] cur;
  logic                   fin;
  logic                   tri_end;

  function automatic tpa_out_t mk_beat(logic [INDEX_WIDTH-1:0] idx, logic tri_b,
                                       logic last, status_t st);
    tpa_out_t b;
    b.vertex_index_out = FIELD_W'(idx);
    b.triangle_done    = tri_b;
    b.list_done        = last;
    b.status           = st;
    return b;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cur      = in_data.vertex_index_in[INDEX_WIDTH-1:0];
  assign fin      = in_data.final_index;
  assign tri_end  = (phase_r >= 2'd2);

  always_comb begin
    first_nxt = first_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    seen_nxt  = seen_r;
    phase_nxt = phase_r;
    odd_nxt   = odd_r;
    job       = '0;

    unique case (mode)
      MODE_LIST: begin
        job.count = 2'd1;
        if (fin && !tri_end) begin
          job.beat[0] = mk_beat('0, 1'b0, 1'b1, ST_BAD_COUNT);
        end else begin
          job.beat[0] = mk_beat(cur, tri_end, fin, ST_OK);
        end
        phase_nxt = tri_end ? 2'd0 : phase_r + 2'd1;
      end
      MODE_STRIP, MODE_FAN: begin
        if (seen_r < 2'd2) begin
          if (fin) begin
            job.count   = 2'd1;
            job.beat[0] = mk_beat('0, 1'b0, 1'b1, ST_BAD_COUNT);
          end
          if (seen_r == 2'd0) first_nxt = cur;
          older_nxt = newer_r;
          newer_nxt = cur;
          seen_nxt  = seen_r + 2'd1;
        end else begin
          job.count = 2'd3;
          if (mode == MODE_STRIP) begin
            job.beat[0] = mk_beat(older_r, 1'b0, 1'b0, ST_OK);
            if (odd_r) begin
              job.beat[1] = mk_beat(cur, 1'b0, 1'b0, ST_OK);
              job.beat[2] = mk_beat(newer_r, 1'b1, fin, ST_OK);
            end else begin
              job.beat[1] = mk_beat(newer_r, 1'b0, 1'b0, ST_OK);
              job.beat[2] = mk_beat(cur, 1'b1, fin, ST_OK);
            end
            odd_nxt = !odd_r;
          end else begin
            job.beat[0] = mk_beat(first_r, 1'b0, 1'b0, ST_OK);
            job.beat[1] = mk_beat(newer_r, 1'b0, 1'b0, ST_OK);
            job.beat[2] = mk_beat(cur, 1'b1, fin, ST_OK);
          end
          older_nxt = newer_r;
          newer_nxt = cur;
        end
      end
      default: begin
        if (fin) begin
          job.count   = 2'd1;
          job.beat[0] = mk_beat('0, 1'b0, 1'b1, ST_BAD_MODE);
        end
      end
    endcase

    // every final index closes the primitive
    if (fin) begin
      first_nxt = '0;
      older_nxt = '0;
      newer_nxt = '0;
      seen_nxt  = '0;
      phase_nxt = '0;
      odd_nxt   = 1'b0;
    end
  end

  assign push = accept && (job.count != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      older_r <= '0;
      newer_r <= '0;
      seen_r  <= '0;
      phase_r <= '0;
      odd_r   <= 1'b0;
    end else if (accept) begin
      first_r <= first_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      seen_r  <= seen_nxt;
      phase_r <= phase_nxt;
      odd_r   <= odd_nxt;
    end
  end

endmodule

[sv/tpa_queue.sv]
// Two-entry job queue between front and back ends.
// Depends on tpa_pkg.
module tpa_queue import tpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tpa_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output tpa_job_t head_job
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  tpa_job_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (cnt_r == CNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/tpa_back.sv]
// Back end: walks each queued job one beat a cycle into the output register while out_ready allows.
// Depends on tpa_pkg.
module tpa_back import tpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  tpa_job_t head_job,
  output logic     pop,
  output logic     out_valid,
  output tpa_out_t out_data,
  input  logic     out_ready
);

  logic [1:0] beat_r, beat_nxt;
  logic       out_valid_r;
  tpa_out_t   out_data_r;
  logic       load;
  logic       last;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign last = (beat_r == head_job.count - 2'd1);
  assign pop  = load && last;

  always_comb begin
    beat_nxt = beat_r;
    if (load) beat_nxt = last ? 2'd0 : beat_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= head_job.beat[beat_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/triangle_primitive_assembly_unit.sv]
// Top level of the triangle primitive assembly block: APB register, front end,
// job queue and back end. Depends on tpa_pkg, tpa_front, tpa_queue, tpa_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_ready  | in_data   (tpa_in_t, one index)
//   out      | out_valid / out_ready| out_data  (tpa_out_t, one list index)
//   cfg      | psel/penable/pwrite  | paddr, pwdata, prdata (topology_mode)
//
// List mode and error results: one beat per index, so one index a cycle while out_ready stays high.
// Strip and fan triangles: three beats per index, sent one after another through
// the single-beat output register of the back end.
// Synchronous active-low reset clears the mode, primitive state and queue.
// The two-entry queue lets the front keep accepting while out_ready is low, until it is full.
module triangle_primitive_assembly_unit import tpa_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // index input
  input  logic        in_valid,
  output logic        in_ready,
  input  tpa_in_t     in_data,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output tpa_out_t    out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // register index lives in paddr[2]; byte lane bits ignored
  localparam logic REG_MODE = 1'b0;

  mode_t    mode_r;
  logic     cfg_wr;
  logic     q_full, q_push, q_pop, q_head_valid;
  tpa_job_t q_push_job, q_head_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LIST;
    end else if (cfg_wr && (paddr[2] == REG_MODE)) begin
      mode_r <= mode_t'(pwdata[1:0]);
    end
  end

  // read back: mode at its slot, zero elsewhere
  assign prdata = (paddr[2] == REG_MODE) ? {30'd0, mode_r} : 32'd0;

  tpa_front #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .mode     (mode_r),
    .q_full   (q_full),
    .push     (q_push),
    .job      (q_push_job)
  );

  tpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  tpa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for the triangle primitive assembly unit.
// Depends on tpa_pkg and triangle_primitive_assembly_unit; reads no files.
// Directed list/strip/fan/unsupported cases, then random primitives under idling and stalls.
module testbench;
  import tpa_pkg::*;

  localparam int unsigned IDX_W         = 32;
  localparam logic [2:0]  MODE_ADDR     = 3'd0;  // topology_mode, register 0
  localparam int          DRAIN_CYCLES  = 20;    // front, queue and output register
  localparam int          LIMIT_CYCLES  = 200000;
  localparam int          REPORT_LIMIT  = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tpa_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tpa_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  triangle_primitive_assembly_unit #(.INDEX_WIDTH(IDX_W)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the mode register and primitive history
  // ---------------------------------------------------------------------------
  mode_t       active_mode = MODE_LIST;
  logic [31:0] first_idx = '0;
  logic [31:0] prev2_idx = '0;   // second newest index of the primitive
  logic [31:0] prev1_idx = '0;   // newest index of the primitive
  logic [1:0]  idx_seen = '0;    // saturates at two
  logic [1:0]  list_corner = '0; // list mode, counts 0..2
  logic        strip_odd = 1'b0;

  tpa_out_t list_index_q[$];     // triangle-list beats still owed by the DUT

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int indices_sent = 0;
  int beats_checked = 0;
  int faults = 0;
  int cycle_count = 0;
  int mode_hits[4] = '{0, 0, 0, 0};

  function automatic tpa_out_t corner(logic [31:0] idx, logic closes, logic last,
                                      status_t st);
    tpa_out_t b;
    b.vertex_index_out = idx;
    b.triangle_done    = closes;
    b.list_done        = last;
    b.status           = st;
    return b;
  endfunction

  // Expected list beats for one accepted index; updates the history as the block should.
  function automatic void assemble_triangles(tpa_in_t beat);
    logic [31:0] cur;
    logic        fin;
    logic        closes;
    cur = beat.vertex_index_in & 32'((64'd1 << IDX_W) - 64'd1);
    fin = beat.final_index;
    mode_hits[active_mode]++;
    case (active_mode)
      MODE_LIST: begin
        closes = (list_corner == 2'd2);
        // a final index that does not close a triangle becomes a bad-count beat
        if (fin && !closes)
          list_index_q.push_back(corner('0, 1'b0, 1'b1, ST_BAD_COUNT));
        else
          list_index_q.push_back(corner(cur, closes, fin, ST_OK));
        list_corner = closes ? 2'd0 : list_corner + 2'd1;
      end
      MODE_STRIP, MODE_FAN: begin
        if (idx_seen < 2'd2) begin
          // too short to close a triangle
          if (fin)
            list_index_q.push_back(corner('0, 1'b0, 1'b1, ST_BAD_COUNT));
          if (idx_seen == 2'd0)
            first_idx = cur;
          idx_seen++;
        end else if (active_mode == MODE_STRIP) begin
          list_index_q.push_back(corner(prev2_idx, 1'b0, 1'b0, ST_OK));
          // odd triangles swap the last two corners to keep the winding
          if (strip_odd) begin
            list_index_q.push_back(corner(cur, 1'b0, 1'b0, ST_OK));
            list_index_q.push_back(corner(prev1_idx, 1'b1, fin, ST_OK));
          end else begin
            list_index_q.push_back(corner(prev1_idx, 1'b0, 1'b0, ST_OK));
            list_index_q.push_back(corner(cur, 1'b1, fin, ST_OK));
          end
          strip_odd = ~strip_odd;
        end else begin
          list_index_q.push_back(corner(first_idx, 1'b0, 1'b0, ST_OK));
          list_index_q.push_back(corner(prev1_idx, 1'b0, 1'b0, ST_OK));
          list_index_q.push_back(corner(cur, 1'b1, fin, ST_OK));
        end
        prev2_idx = prev1_idx;
        prev1_idx = cur;
      end
      default: begin
        // unsupported mode: silent until the final index
        if (fin)
          list_index_q.push_back(corner('0, 1'b0, 1'b1, ST_BAD_MODE));
      end
    endcase
    if (fin) begin
      first_idx   = '0;
      prev2_idx   = '0;
      prev1_idx   = '0;
      idx_seen    = '0;
      list_corner = '0;
      strip_odd   = 1'b0;
    end
  endfunction

  // Input and register monitor: everything sampled at the edge that moves the beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
        active_mode = mode_t'(pwdata[1:0]);
      if (in_valid && in_ready)
        assemble_triangles(in_data);
    end
  end

  // Result checker: oldest expectation against each accepted output beat
  always @(posedge clk) begin
    tpa_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (list_index_q.size() == 0) begin
        if (faults < REPORT_LIMIT)
          $display("[%0d] unexpected beat: idx=%h tri=%b last=%b status=%0d", cycle_count,
                   out_data.vertex_index_out, out_data.triangle_done,
                   out_data.list_done, out_data.status);
        faults++;
      end else begin
        want = list_index_q.pop_front();
        beats_checked++;
        if (out_data.vertex_index_out !== want.vertex_index_out ||
            out_data.triangle_done !== want.triangle_done ||
            out_data.list_done !== want.list_done ||
            out_data.status !== want.status) begin
          if (faults < REPORT_LIMIT)
            $display("[%0d] mismatch: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                     cycle_count, want.vertex_index_out, want.triangle_done,
                     want.list_done, want.status, out_data.vertex_index_out,
                     out_data.triangle_done, out_data.list_done, out_data.status);
          faults++;
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d beats still owed", cycle_count,
               list_index_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // One index beat; valid is left high on return so back-to-back beats stay gapless
  task automatic send_index(input logic [31:0] idx, input logic is_last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{vertex_index_in: idx, final_index: is_last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    indices_sent++;
  endtask

  // Drop valid, wait for every owed beat, then let silent indices finish too
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (list_index_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write topology_mode while idle, then read it back
  task automatic program_mode(input mode_t m);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= 32'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[1:0] !== m) begin
      if (faults < REPORT_LIMIT)
        $display("[%0d] mode readback: exp %0d got %0d", cycle_count, m, prdata[1:0]);
      faults++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset mode is list: one good triangle with extreme indices, then a short list
  task automatic test_list_mode();
    send_index(32'h0000_0000, 1'b0);
    send_index(32'hFFFF_FFFF, 1'b0);
    send_index(32'h0000_0001, 1'b1);
    send_index(32'd5, 1'b0);
    send_index(32'd6, 1'b1);
  endtask

  // Strip with odd-triangle swaps, then strips of one and two indices
  task automatic test_strip_mode();
    program_mode(MODE_STRIP);
    for (int k = 10; k <= 14; k++)
      send_index(32'(k), k == 14);
    send_index(32'd7, 1'b1);
    send_index(32'd8, 1'b0);
    send_index(32'd9, 1'b1);
  endtask

  task automatic test_fan_mode();
    program_mode(MODE_FAN);
    for (int k = 20; k <= 23; k++)
      send_index(32'(k), k == 23);
  endtask

  task automatic test_bad_mode();
    program_mode(MODE_BAD);
    send_index(32'd30, 1'b0);
    send_index(32'd31, 1'b1);
  endtask

  // Mode changed inside an open primitive: list keeps its own counter, strip and fan share history
  task automatic test_mode_switch();
    program_mode(MODE_FAN);
    send_index(32'd40, 1'b0);
    send_index(32'd41, 1'b0);
    program_mode(MODE_LIST);
    send_index(32'd42, 1'b0);
    program_mode(MODE_STRIP);
    send_index(32'd43, 1'b1);
  endtask

  // Mostly well-formed primitives, some short or unterminated ones
  task automatic test_random_primitives(input int idle_pct, input int stall_pct,
                                        input int quota);
    int          counted;
    int          len;
    int          pick;
    mode_t       m;
    logic [31:0] idx;
    bit          drop_last;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    counted = 0;
    while (counted < quota) begin
      pick = $urandom_range(9);
      m = (pick < 3) ? MODE_LIST : (pick < 6) ? MODE_STRIP : (pick < 9) ? MODE_FAN : MODE_BAD;
      program_mode(m);
      repeat ($urandom_range(2, 4)) begin
        case (m)
          MODE_LIST: len = ($urandom_range(3) == 0) ? $urandom_range(1, 8)
                                                   : 3 * $urandom_range(1, 3);
          MODE_BAD:  len = $urandom_range(1, 4);
          default:   len = ($urandom_range(4) == 0) ? $urandom_range(1, 2)
                                                   : $urandom_range(3, 9);
        endcase
        // an unterminated primitive carries its state into the next mode
        drop_last = ($urandom_range(9) == 0);
        for (int k = 1; k <= len; k++) begin
          case ($urandom_range(15))
            0:       idx = '0;
            1:       idx = '1;
            default: idx = $urandom;
          endcase
          send_index(idx, k == len && !drop_last);
          if (m != MODE_BAD || (k == len && !drop_last))
            counted++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_list_mode();
    test_strip_mode();
    test_fan_mode();
    test_bad_mode();
    test_mode_switch();

    test_random_primitives(0, 0, 32);
    test_random_primitives(57, 0, 32);
    test_random_primitives(0, 57, 32);
    test_random_primitives(31, 31, 32);

    settle();
    if (list_index_q.size() != 0) begin
      $display("%0d expected beats never arrived", list_index_q.size());
      faults++;
    end

    $display("Sent %0d indices (list %0d, strip %0d, fan %0d, unsupported %0d)",
             indices_sent, mode_hits[MODE_LIST], mode_hits[MODE_STRIP],
             mode_hits[MODE_FAN], mode_hits[MODE_BAD]);
    $display("Checked %0d list beats across four idling phases, %0d faults",
             beats_checked, faults);
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tpa_pkg.sv
sv/tpa_front.sv
sv/tpa_queue.sv
sv/tpa_back.sv
sv/triangle_primitive_assembly_unit.sv
bench/testbench.sv
